[rtl/assert_macros.svh]
// Assertion macros for the checker module.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at each rising clock edge, ignored while reset is high.
`define LCRF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at each rising clock edge, reset included.
`define LCRF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/lcrf_pkg.sv]
// Package for the line counting receive FIFO: sizes, op codes and
// controller command type. No dependencies.
`timescale 1ns / 1ps

package lcrf_pkg;

   localparam int FIFO_DEPTH = 64;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = 7;

   localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(FIFO_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(FIFO_DEPTH);

   localparam logic [7:0] LINE_FEED = 8'h0A;

   localparam logic [1:0] OP_PUSH  = 2'd0;
   localparam logic [1:0] OP_POP   = 2'd1;
   localparam logic [1:0] OP_FLUSH = 2'd2;

   typedef struct packed {
      logic load;
      logic commit;
   } ctrl_cmd_type;

endpackage

[rtl/lcrf_req_if.sv]
// Request channel: op and received byte with valid/ready handshake.
// Depends on nothing.
`timescale 1ns / 1ps

interface lcrf_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [7:0] rx_byte;

   modport source (output valid, output op, output rx_byte, input ready);
   modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

[rtl/lcrf_rsp_if.sv]
// Response channel: popped byte and FIFO status with valid/ready handshake.
// Depends on nothing.
`timescale 1ns / 1ps

interface lcrf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_byte;
   logic       was_empty;
   logic [6:0] fill_level;
   logic [6:0] lines_held;
   logic       overflowed;

   modport source (output valid, output read_byte, output was_empty,
                   output fill_level, output lines_held, output overflowed,
                   input ready);
   modport sink   (input valid, input read_byte, input was_empty,
                   input fill_level, input lines_held, input overflowed,
                   output ready);
endinterface

[rtl/lcrf_ctrl.sv]
// Controller for the line counting receive FIFO: transaction sequencing
// and response valid. Depends on lcrf_pkg.
`timescale 1ns / 1ps

module lcrf_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output lcrf_pkg::ctrl_cmd_type cmd
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic commit;

   assign req_ready  = (state_ff == S_IDLE);
   assign commit     = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign cmd.load   = req_valid && req_ready;
   assign cmd.commit = commit;
   assign rsp_valid  = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (commit) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[rtl/lcrf_datapath.sv]
// Datapath for the line counting receive FIFO: byte memory, pointers,
// counters, overflow flag and response register. Depends on lcrf_pkg.
`timescale 1ns / 1ps

module lcrf_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  lcrf_pkg::ctrl_cmd_type      cmd,
   input  logic [1:0]                  req_op,
   input  logic [7:0]                  req_rx_byte,
   output logic [7:0]                  rsp_read_byte,
   output logic                        rsp_was_empty,
   output logic [lcrf_pkg::CNT_W-1:0]  rsp_fill_level,
   output logic [lcrf_pkg::CNT_W-1:0]  rsp_lines_held,
   output logic                        rsp_overflowed
);

   logic [7:0] mem [lcrf_pkg::FIFO_DEPTH];

   logic [1:0]                 op_ff;
   logic [7:0]                 byte_ff;
   logic [7:0]                 head_ff;
   logic [lcrf_pkg::PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [lcrf_pkg::PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [lcrf_pkg::CNT_W-1:0] held_ff, held_in;
   logic [lcrf_pkg::CNT_W-1:0] lines_ff, lines_in;
   logic                       ovf_ff, ovf_in;
   logic                       mem_we;
   logic [7:0]                 rd_byte_in;
   logic                       empty_in;

   logic [7:0]                 out_byte_ff;
   logic                       out_empty_ff;

   always_comb begin
      rd_ptr_in  = rd_ptr_ff;
      wr_ptr_in  = wr_ptr_ff;
      held_in    = held_ff;
      lines_in   = lines_ff;
      ovf_in     = ovf_ff;
      mem_we     = 1'b0;
      rd_byte_in = 8'd0;
      empty_in   = 1'b0;
      case (op_ff)
         lcrf_pkg::OP_PUSH: begin
            if (held_ff != lcrf_pkg::CNT_FULL) begin
               mem_we    = 1'b1;
               wr_ptr_in = (wr_ptr_ff == lcrf_pkg::PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
               held_in   = held_ff + 1'b1;
               if (byte_ff == lcrf_pkg::LINE_FEED) lines_in = lines_ff + 1'b1;
               ovf_in    = 1'b0;
            end else begin
               ovf_in = 1'b1;
            end
         end
         lcrf_pkg::OP_POP: begin
            if (held_ff != '0) begin
               rd_byte_in = head_ff;
               rd_ptr_in  = (rd_ptr_ff == lcrf_pkg::PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
               held_in    = held_ff - 1'b1;
               if (head_ff == lcrf_pkg::LINE_FEED && lines_ff != '0) begin
                  lines_in = lines_ff - 1'b1;
               end
            end else begin
               empty_in = 1'b1;
            end
         end
         lcrf_pkg::OP_FLUSH: begin
            rd_ptr_in = '0;
            wr_ptr_in = '0;
            held_in   = '0;
            lines_in  = '0;
            ovf_in    = 1'b0;
         end
         default: ;
      endcase
   end

   // head byte is fetched at accept; read pointer only moves on commit
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_op;
         byte_ff <= req_rx_byte;
         head_ff <= mem[rd_ptr_ff];
      end
      if (cmd.commit && mem_we) begin
         mem[wr_ptr_ff] <= byte_ff;
      end
      if (cmd.commit) begin
         out_byte_ff  <= rd_byte_in;
         out_empty_ff <= empty_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         held_ff   <= '0;
         lines_ff  <= '0;
         ovf_ff    <= 1'b0;
      end else if (cmd.commit) begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         held_ff   <= held_in;
         lines_ff  <= lines_in;
         ovf_ff    <= ovf_in;
      end
   end

   // counters and flag only change on commit, so they double as response fields
   assign rsp_read_byte  = out_byte_ff;
   assign rsp_was_empty  = out_empty_ff;
   assign rsp_fill_level = held_ff;
   assign rsp_lines_held = lines_ff;
   assign rsp_overflowed = ovf_ff;

endmodule

[rtl/line_counting_receive_fifo_unit.sv]
// Line counting receive FIFO, 64 bytes: push, pop and flush transactions.
// Sequence: a request is latched on accept and committed in the exec state
// once the previous response has been taken; no new request is accepted
// until commit; the head byte is read from the registered memory port.
// Reset: synchronous; pointers, counts and overflow flag clear, memory is not.
`timescale 1ns / 1ps

module line_counting_receive_fifo_unit (
   input  logic         clock,
   input  logic         reset,
   lcrf_req_if.sink     req_ch,
   lcrf_rsp_if.source   rsp_ch
);

   lcrf_pkg::ctrl_cmd_type cmd;

   lcrf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   lcrf_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_op         (req_ch.op),
      .req_rx_byte    (req_ch.rx_byte),
      .rsp_read_byte  (rsp_ch.read_byte),
      .rsp_was_empty  (rsp_ch.was_empty),
      .rsp_fill_level (rsp_ch.fill_level),
      .rsp_lines_held (rsp_ch.lines_held),
      .rsp_overflowed (rsp_ch.overflowed)
   );

endmodule

[rtl/lcrf_checker.sv]
// Port-level checker for the line counting receive FIFO, bound to the top.
// Depends on assert_macros.svh and lcrf_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lcrf_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_read_byte,
   input logic       rsp_was_empty,
   input logic [6:0] rsp_fill_level,
   input logic [6:0] rsp_lines_held
);

   `LCRF_ASSERT_ALWAYS(a_no_rsp_after_reset, clock, reset |=> !rsp_valid, "response valid after reset")
   `LCRF_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "response dropped while stalled")
   `LCRF_ASSERT(a_fill_range, clock, reset, rsp_valid |-> rsp_fill_level <= 7'(lcrf_pkg::FIFO_DEPTH), "fill level above depth")
   `LCRF_ASSERT(a_lines_le_fill, clock, reset, rsp_valid |-> rsp_lines_held <= rsp_fill_level, "more lines than bytes held")
   `LCRF_ASSERT(a_empty_pop, clock, reset, rsp_valid && rsp_was_empty |-> rsp_read_byte == 8'd0 && rsp_fill_level == 7'd0, "empty pop with data")

endmodule

bind line_counting_receive_fifo_unit lcrf_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_read_byte  (rsp_ch.read_byte),
   .rsp_was_empty  (rsp_ch.was_empty),
   .rsp_fill_level (rsp_ch.fill_level),
   .rsp_lines_held (rsp_ch.lines_held)
);
